// File: rtl/assert_macros.svh
// Assertion macros shared by the replacement block RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge, off while reset is high.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: check failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: check failed");

`endif

// File: rtl/prlru_pkg.sv
// Shared sizes, types and cell control word for the page replacement block.
// No dependencies.
`default_nettype none

package prlru_pkg;

   localparam int FRAMES    = 4;
   localparam int PAGE_BITS = 16;
   localparam int CNT_BITS  = 16;

   localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   // Policy codes of the csr register
   typedef enum logic {
      POLICY_FIFO = 1'b0,
      POLICY_LRU  = 1'b1
   } policy_type;

   // Broadcast control for every frame cell
   typedef struct packed {
      logic     move_all;    // miss with all frames full: whole row shifts down
      logic     move_after;  // LRU hit: cells at or above the hit shift down
      logic     fill;        // miss with a free frame: first empty cell loads
      page_type page;        // referenced page
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/prlru_cell.sv
// One frame cell: holds a page and its valid bit, compares against the
// referenced page and takes its upper neighbor's page on a shift. Uses prlru_pkg.
`default_nettype none

module prlru_cell
   import prlru_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic          prev_valid,  // lower neighbor occupied (1 for cell 0)
   input  wire logic          prev_seen,   // hit found at a lower position
   input  wire logic          next_valid,  // upper neighbor occupied
   input  wire page_type      next_page,   // upper neighbor's page
   output logic               seen,        // hit at or below this cell
   output logic               valid,
   output page_type           page
);

   logic     valid_ff, valid_in;
   page_type page_ff, page_in;
   logic     shift_now;

   assign seen  = prev_seen | (valid_ff & (page_ff == ctrl.page));
   assign valid = valid_ff;
   assign page  = page_ff;

   // Next page: shift from above, or take the new page at the top of the row
   always_comb begin
      shift_now = valid_ff & (ctrl.move_all | (ctrl.move_after & seen));
      valid_in  = valid_ff;
      page_in   = page_ff;
      if (shift_now) begin
         page_in = next_valid ? next_page : ctrl.page;
      end else if (ctrl.fill & ~valid_ff & prev_valid) begin
         page_in  = ctrl.page;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

endmodule

`default_nettype wire

// File: rtl/page_replacement_fifo_lru.sv
// Page replacement, FIFO or LRU, over a row of frame cells oldest first.
// A result word is registered and appears in the cycle after its request word is accepted.
// Throughput: one word per cycle while results are taken; the compare-and-shift over the cell row
// finishes in the accepting cycle, the output register frees the input side.
// Reset (synchronous): all frames empty, counters zero, policy LRU.
`default_nettype none
`include "assert_macros.svh"

module page_replacement_fifo_lru
   import prlru_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request: [15:0] page_number
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,
   // response: [0] hit, [1] evicted_valid, [17:2] evicted_page,
   // [33:18] hits_so_far, [49:34] faults_so_far, [55:50] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,
   // policy register
   input  wire logic        csr_wen,
   input  wire logic        csr_wdata
);

   policy_type    policy_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          hit_ff;
   logic          ev_valid_ff;
   page_type      ev_page_ff;
   cnt_type       hit_cnt_ff, hit_cnt_in;
   cnt_type       fault_cnt_ff, fault_cnt_in;

   logic          accept;
   logic          hit;
   logic          full;
   cell_ctrl_type ctrl;

   logic [FRAMES-1:0] seen_w;
   logic [FRAMES-1:0] valid_w;
   page_type          page_w [FRAMES];
   logic [FRAMES-1:0] valid_chk;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign hit        = seen_w[FRAMES-1];
   assign full       = valid_w[FRAMES-1];

   // Broadcast control to the row, gated by the request handshake
   always_comb begin
      ctrl.page       = req_tdata[PAGE_BITS-1:0];
      ctrl.move_after = accept & hit & (policy_ff == POLICY_LRU);
      ctrl.move_all   = accept & ~hit & full;
      ctrl.fill       = accept & ~hit & ~full;
   end

   // Row of frame cells, oldest at index 0
   for (genvar i = 0; i < FRAMES; i++) begin : g_cell
      logic     prev_valid_w;
      logic     prev_seen_w;
      logic     next_valid_w;
      page_type next_page_w;

      if (i == 0) begin : g_first
         assign prev_valid_w = 1'b1;
         assign prev_seen_w  = 1'b0;
      end else begin : g_mid
         assign prev_valid_w = valid_w[i-1];
         assign prev_seen_w  = seen_w[i-1];
      end

      if (i == FRAMES-1) begin : g_last
         assign next_valid_w = 1'b0;
         assign next_page_w  = '0;
      end else begin : g_up
         assign next_valid_w = valid_w[i+1];
         assign next_page_w  = page_w[i+1];
      end

      prlru_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_valid (prev_valid_w),
         .prev_seen  (prev_seen_w),
         .next_valid (next_valid_w),
         .next_page  (next_page_w),
         .seen       (seen_w[i]),
         .valid      (valid_w[i]),
         .page       (page_w[i])
      );
   end

   // Saturating counters and output valid
   always_comb begin
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      if (accept) begin
         if (hit) begin
            if (hit_cnt_ff != CNT_MAX) hit_cnt_in = hit_cnt_ff + 1'b1;
         end else begin
            if (fault_cnt_ff != CNT_MAX) fault_cnt_in = fault_cnt_ff + 1'b1;
         end
      end
      rsp_valid_in = accept | (rsp_valid_ff & ~rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POLICY_LRU;
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
      end else begin
         if (csr_wen) policy_ff <= policy_type'(csr_wdata);
         rsp_valid_ff <= rsp_valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
      end
   end

   // Result word payload
   always_ff @(posedge clock) begin
      if (accept) begin
         hit_ff      <= hit;
         ev_valid_ff <= ~hit & full;
         ev_page_ff  <= (~hit & full) ? page_w[0] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, fault_cnt_ff, hit_cnt_ff, ev_page_ff, ev_valid_ff, hit_ff};

   // Occupied frames always form a prefix from the oldest position
   assign valid_chk = valid_w & (valid_w + 1'b1);

   `ASSERT_IMPL(a_valid_prefix, clock, reset, 1'b1, valid_chk == '0)
   `ASSERT_IMPL(a_evict_on_miss, clock, reset, rsp_valid_ff & ev_valid_ff, ~hit_ff)
   `ASSERT_NEXT(a_hit_count, clock, reset, accept & hit & (hit_cnt_ff != CNT_MAX),
                hit_cnt_ff == $past(hit_cnt_ff) + 1'b1)
   `ASSERT_NEXT(a_fill_grows, clock, reset, accept & ~hit & ~full,
                $countones(valid_w) == $countones($past(valid_w)) + 1)

endmodule

`default_nettype wire
